// ----- rtl/x86s_pkg.sv -----
`default_nettype none
package x86s_pkg;

  localparam int MemAddrBitsDefault = 16;

  // request codes
  localparam logic [1:0] REQ_MEM_WR = 2'd0;
  localparam logic [1:0] REQ_STEP   = 2'd1;
  localparam logic [1:0] REQ_REG_RD = 2'd2;
  localparam logic [1:0] REQ_MEM_RD = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_DEC_ERR  = 2'd2;
  localparam logic [1:0] ST_NOT_EXEC = 2'd3;

  typedef enum logic {ALU_ADD, ALU_SUB} alu_op_e;
  typedef enum logic [1:0] {K_MOV, K_ADD, K_SUB, K_CMP} kind_e;

  // opcode masks and patterns
  localparam logic [7:0] MASK_FC = 8'b11111100;
  localparam logic [7:0] MASK_F0 = 8'b11110000;
  localparam logic [7:0] MASK_FE = 8'b11111110;

  localparam logic [7:0] OPC_ADD_RM  = 8'h00;
  localparam logic [7:0] OPC_SUB_RM  = 8'h28;
  localparam logic [7:0] OPC_CMP_RM  = 8'h38;
  localparam logic [7:0] OPC_MOV_RM  = 8'h88;
  localparam logic [7:0] OPC_ADD_ACC = 8'h04;
  localparam logic [7:0] OPC_SUB_ACC = 8'h2C;
  localparam logic [7:0] OPC_CMP_ACC = 8'h3C;
  localparam logic [7:0] OPC_MOV_RI  = 8'b10110000;
  localparam logic [7:0] OPC_MOV_MI  = 8'hC6;
  localparam logic [7:0] OPC_GRP     = 8'b10000000;
  localparam logic [7:0] OPC_JCC     = 8'h70;
  localparam logic [7:0] OPC_LOOP    = 8'hE0;
  localparam logic [7:0] OPC_JE      = 8'h74;
  localparam logic [7:0] OPC_JNE     = 8'h75;
  localparam logic [7:0] OPC_JS      = 8'h78;
  localparam logic [7:0] OPC_JNS     = 8'h79;

  localparam logic [7:0] MODRM_MID_MASK = 8'b00111000;
  localparam logic [2:0] GRP_ADD = 3'b000;
  localparam logic [2:0] GRP_SUB = 3'b101;
  localparam logic [2:0] GRP_CMP = 3'b111;
  localparam logic [2:0] RM_DIRECT = 3'b110;

  function automatic logic [15:0] sext8(input logic [7:0] v);
    return {{8{v[7]}}, v};
  endfunction

  // register number to word slot
  function automatic logic [2:0] word_idx(input logic [3:0] idx);
    return idx[3] ? idx[2:0] : {1'b0, idx[1:0]};
  endfunction

  // select byte or word from a slot, byte registers zero-extended
  function automatic logic [15:0] reg_fmt(input logic [3:0] idx, input logic [15:0] word);
    if (idx[3]) return word;
    else if (idx[2]) return {8'h00, word[15:8]};
    else return {8'h00, word[7:0]};
  endfunction

  function automatic logic [2:0] ea_base1(input logic [2:0] rm);
    logic [2:0] r;
    unique case (rm)
      3'd0, 3'd1, 3'd7: r = 3'd3;
      3'd2, 3'd3, 3'd6: r = 3'd5;
      3'd4:             r = 3'd6;
      default:          r = 3'd7;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] ea_base2(input logic [2:0] rm);
    return {2'b11, rm[0]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/x86s_chan_if.sv -----
`default_nettype none
interface x86s_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] address;
  logic [7:0]  write_byte;
  logic [3:0]  reg_index;
  modport source (output valid, req_type, address, write_byte, reg_index, input ready);
  modport sink   (input valid, req_type, address, write_byte, reg_index, output ready);
endinterface

interface x86s_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_value;
  logic [15:0] instr_pointer;
  logic        zero_flag;
  logic        sign_flag;
  logic [1:0]  status;
  modport source (output valid, read_value, instr_pointer, zero_flag, sign_flag, status,
                  input ready);
  modport sink   (input valid, read_value, instr_pointer, zero_flag, sign_flag, status,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/x86s_mem.sv -----
`default_nettype none
module x86s_mem #(
  parameter int MEM_ADDR_BITS = x86s_pkg::MemAddrBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  output logic        busy_o,
  input  logic        re_i,
  input  logic [15:0] raddr_i,
  output logic [7:0]  rdata_o,
  input  logic        we_i,
  input  logic [15:0] waddr_i,
  input  logic [7:0]  wdata_i
);
  localparam int Depth = 2 ** MEM_ADDR_BITS;

  logic [7:0] mem [Depth];
  logic [MEM_ADDR_BITS-1:0] clr_q;
  logic busy_q;
  logic [7:0] rdata_q;

  // clearing pass after reset, one byte per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (&clr_q) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) mem[clr_q] <= 8'h00;
    else if (we_i) mem[MEM_ADDR_BITS'(waddr_i)] <= wdata_i;
    if (re_i) rdata_q <= mem[MEM_ADDR_BITS'(raddr_i)];
  end

  assign busy_o  = busy_q;
  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/x86s_rf.sv -----
`default_nettype none
module x86s_rf (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [2:0]  raddr_i,
  output logic [15:0] rdata_o,
  input  logic        we_i,
  input  logic [3:0]  widx_i,
  input  logic [15:0] wdata_i
);
  logic [15:0] regs_q [8];
  logic [15:0] rdata_q;
  logic [2:0]  wslot;

  assign wslot = x86s_pkg::word_idx(widx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) regs_q[i] <= '0;
    end else if (we_i) begin
      if (widx_i[3]) regs_q[wslot] <= wdata_i;
      else if (widx_i[2]) regs_q[wslot][15:8] <= wdata_i[7:0];
      else regs_q[wslot][7:0] <= wdata_i[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= regs_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

// ----- rtl/x86s_alu.sv -----
`default_nettype none
module x86s_alu (
  input  x86s_pkg::alu_op_e op_i,
  input  logic              w_i,
  input  logic [15:0]       a_i,
  input  logic [15:0]       b_i,
  output logic [15:0]       y_o,
  output logic              zf_o,
  output logic              sf_o
);
  always_comb begin
    unique case (op_i)
      x86s_pkg::ALU_SUB: y_o = a_i - b_i;
      default:           y_o = a_i + b_i;
    endcase
  end

  assign zf_o = w_i ? (y_o == 16'h0000) : (y_o[7:0] == 8'h00);
  assign sf_o = w_i ? y_o[15] : y_o[7];
endmodule
`default_nettype wire

// ----- rtl/x86_16_subset_decode_execute.sv -----
// Subset 16-bit x86 core over a byte memory of 2^MEM_ADDR_BITS bytes.
// Request channel req_i: write memory byte, step one instruction, read a
// register or read a memory byte. Response channel rsp_o: one result per
// request (read value, ip, zero and sign flags, status).
// cfg_we_i/cfg_wdata_i set the program length; write it while idle.
// A step fetches its bytes in order (opcode, modrm, disp, immediate), forms
// the effective address in S_EA_B1, S_EA_B2 and S_EA_DISP, reads any memory
// operand bytes, reads the operand in S_OPR1, executes in S_EXEC, stores a
// high byte in S_WR_HI when needed, then finishes in S_DONE and loads the
// output register. All work is sequenced over one byte-wide memory read port
// and one write port, one register file read port and one shared adder. One
// request is in flight at a time.
// After reset all 2^MEM_ADDR_BITS memory bytes are cleared, one byte per cycle;
// req_i.ready stays low meanwhile. Registers, ip and flags reset to 0.
// A result waits in an output register while rsp_o.ready is low; the next
// request is taken and worked on, and its result waits until the slot frees.
`default_nettype none
module x86_16_subset_decode_execute #(
  parameter int MEM_ADDR_BITS = x86s_pkg::MemAddrBitsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [16:0]  cfg_wdata_i,
  x86s_req_if.sink     req_i,
  x86s_rsp_if.source   rsp_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_MRD_D, S_REGRD_D, S_OP_D, S_MODRM_D, S_DISP_LO_D, S_DISP_HI_D,
    S_IMM_LO_D, S_IMM_HI_D, S_EA_B1, S_EA_B2, S_EA_DISP, S_RD_LO_D, S_RD_HI_D,
    S_OPR1, S_EXEC, S_WR_HI, S_JMP_D, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic [15:0] tip_q, tip_d, ip_q, ip_d;
  logic        zf_q, zf_d, sf_q, sf_d;
  logic [16:0] prog_len_q;
  x86s_pkg::kind_e kind_q, kind_d;
  logic w_q, w_d, d_q, d_d, has_imm_q, has_imm_d, imm_wide_q, imm_wide_d;
  logic is_c6_q, is_c6_d, is_grp_q, is_grp_d;
  logic [7:0]  modrm_q, modrm_d;
  logic        rm_mem_q, rm_mem_d;
  logic [3:0]  rm_reg_q, rm_reg_d, reg_idx_q, reg_idx_d;
  logic [15:0] disp_q, disp_d, imm_q, imm_d, ea_q, ea_d, mval_q, mval_d;
  logic [15:0] rmv_q, rmv_d, res_q, res_d, rv_q, rv_d;
  logic [1:0]  st_q, st_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_rv_q, out_rv_d, out_ip_q, out_ip_d;
  logic        out_zf_q, out_zf_d, out_sf_q, out_sf_d;
  logic [1:0]  out_st_q, out_st_d;

  logic        mem_busy, mem_re, mem_we;
  logic [15:0] mem_raddr, mem_waddr;
  logic [7:0]  mem_rdata, mem_wdata;
  logic [2:0]  rf_raddr;
  logic [15:0] rf_rdata, rf_wdata;
  logic        rf_we;
  logic [3:0]  rf_widx;
  x86s_pkg::alu_op_e alu_op;
  logic [15:0] alu_a, alu_b, alu_y;
  logic        alu_zf, alu_sf;

  logic        accept;
  logic [7:0]  b;
  logic [1:0]  mod_f;
  logic [2:0]  mid_f, rm_f;
  logic        need_disp, disp_wide, dst_regf, direct;
  logic [15:0] mask, dst_v, src_v, res;
  logic        take;
  state_e      after_imm, after_disp;

  x86s_mem #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_mem (
    .clk_i, .rst_ni, .busy_o(mem_busy), .re_i(mem_re), .raddr_i(mem_raddr),
    .rdata_o(mem_rdata), .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata)
  );

  x86s_rf u_rf (
    .clk_i, .rst_ni, .raddr_i(rf_raddr), .rdata_o(rf_rdata), .we_i(rf_we),
    .widx_i(rf_widx), .wdata_i(rf_wdata)
  );

  x86s_alu u_alu (
    .op_i(alu_op), .w_i(w_q), .a_i(alu_a), .b_i(alu_b), .y_o(alu_y),
    .zf_o(alu_zf), .sf_o(alu_sf)
  );

  assign req_i.ready = (state_q == S_IDLE) && !mem_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign b           = mem_rdata;
  assign mod_f       = b[7:6];
  assign mid_f       = b[5:3];
  assign rm_f        = b[2:0];
  assign direct      = (modrm_q[7:6] == 2'd0) && (modrm_q[2:0] == x86s_pkg::RM_DIRECT);
  assign mask        = w_q ? 16'hFFFF : 16'h00FF;
  assign dst_regf    = d_q && !has_imm_q;
  assign after_imm   = rm_mem_q ? S_EA_B1 : S_OPR1;
  assign after_disp  = has_imm_q ? S_IMM_LO_D : S_EA_B1;

  assign dst_v = dst_regf ? x86s_pkg::reg_fmt(reg_idx_q, rf_rdata) : rmv_q;
  assign src_v = has_imm_q ? (imm_q & mask) :
                 dst_regf ? rmv_q : x86s_pkg::reg_fmt(reg_idx_q, rf_rdata);
  assign res   = ((kind_q == x86s_pkg::K_MOV) ? src_v : alu_y) & mask;

  // jump condition from the held opcode
  always_comb begin
    unique case (modrm_q)
      x86s_pkg::OPC_JE:  take = zf_q;
      x86s_pkg::OPC_JNE: take = !zf_q;
      x86s_pkg::OPC_JS:  take = sf_q;
      x86s_pkg::OPC_JNS: take = !sf_q;
      default:           take = 1'b0;
    endcase
  end

  // shared adder operand selection
  always_comb begin
    alu_op = x86s_pkg::ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    unique case (state_q)
      S_EA_B2: begin
        alu_a = ea_q;
        alu_b = (direct || modrm_q[2]) ? 16'h0000 : rf_rdata;
      end
      S_EA_DISP: begin
        alu_a = ea_q;
        alu_b = disp_q;
      end
      S_EXEC: begin
        alu_a = dst_v;
        alu_b = src_v;
        if (kind_q == x86s_pkg::K_SUB || kind_q == x86s_pkg::K_CMP) alu_op = x86s_pkg::ALU_SUB;
      end
      S_JMP_D: begin
        alu_a = tip_q;
        alu_b = x86s_pkg::sext8(b);
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    ip_d = ip_q; zf_d = zf_q; sf_d = sf_q;
    kind_d = kind_q; w_d = w_q; d_d = d_q; has_imm_d = has_imm_q; imm_wide_d = imm_wide_q;
    is_c6_d = is_c6_q; is_grp_d = is_grp_q; modrm_d = modrm_q;
    rm_mem_d = rm_mem_q; rm_reg_d = rm_reg_q; reg_idx_d = reg_idx_q;
    disp_d = disp_q; imm_d = imm_q; ea_d = ea_q; mval_d = mval_q; rmv_d = rmv_q;
    res_d = res_q; rv_d = rv_q; st_d = st_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_rv_d = out_rv_q; out_ip_d = out_ip_q; out_zf_d = out_zf_q;
    out_sf_d = out_sf_q; out_st_d = out_st_q;
    mem_we = 1'b0; mem_waddr = ea_q; mem_wdata = res[7:0];
    rf_we = 1'b0; rf_widx = dst_regf ? reg_idx_q : rm_reg_q; rf_wdata = res;
    need_disp = 1'b0; disp_wide = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          rv_d = '0;
          st_d = x86s_pkg::ST_OK;
          unique case (req_i.req_type)
            x86s_pkg::REQ_MEM_WR: begin
              mem_we    = 1'b1;
              mem_waddr = req_i.address;
              mem_wdata = req_i.write_byte;
              state_d   = S_DONE;
            end
            x86s_pkg::REQ_STEP: begin
              if ({1'b0, ip_q} >= prog_len_q) begin
                st_d    = x86s_pkg::ST_FINISHED;
                state_d = S_DONE;
              end else begin
                state_d = S_OP_D;
              end
            end
            x86s_pkg::REQ_REG_RD: begin
              reg_idx_d = req_i.reg_index;
              state_d   = S_REGRD_D;
            end
            default: state_d = S_MRD_D;
          endcase
        end
      end
      S_MRD_D: begin
        rv_d    = {8'h00, b};
        state_d = S_DONE;
      end
      S_REGRD_D: begin
        rv_d    = x86s_pkg::reg_fmt(reg_idx_q, rf_rdata);
        state_d = S_DONE;
      end
      S_OP_D: begin
        is_c6_d = 1'b0; is_grp_d = 1'b0; d_d = 1'b0; has_imm_d = 1'b1;
        rm_mem_d = 1'b0; w_d = b[0]; imm_wide_d = b[0];
        priority if ((b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_ADD_RM ||
                     (b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_SUB_RM ||
                     (b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_CMP_RM ||
                     (b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_MOV_RM) begin
          unique case (b & x86s_pkg::MASK_FC)
            x86s_pkg::OPC_MOV_RM: kind_d = x86s_pkg::K_MOV;
            x86s_pkg::OPC_ADD_RM: kind_d = x86s_pkg::K_ADD;
            x86s_pkg::OPC_SUB_RM: kind_d = x86s_pkg::K_SUB;
            default:              kind_d = x86s_pkg::K_CMP;
          endcase
          d_d = b[1]; has_imm_d = 1'b0;
          state_d = S_MODRM_D;
        end else if ((b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_ADD_ACC ||
                     (b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_SUB_ACC ||
                     (b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_CMP_ACC) begin
          unique case (b & x86s_pkg::MASK_FE)
            x86s_pkg::OPC_ADD_ACC: kind_d = x86s_pkg::K_ADD;
            x86s_pkg::OPC_SUB_ACC: kind_d = x86s_pkg::K_SUB;
            default:               kind_d = x86s_pkg::K_CMP;
          endcase
          rm_reg_d = {b[0], 3'b000};
          state_d  = S_IMM_LO_D;
        end else if ((b & x86s_pkg::MASK_F0) == x86s_pkg::OPC_MOV_RI) begin
          kind_d = x86s_pkg::K_MOV;
          w_d = b[3]; imm_wide_d = b[3];
          rm_reg_d = {b[3], b[2:0]};
          state_d  = S_IMM_LO_D;
        end else if ((b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_MOV_MI) begin
          kind_d  = x86s_pkg::K_MOV;
          is_c6_d = 1'b1;
          state_d = S_MODRM_D;
        end else if ((b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_GRP) begin
          is_grp_d   = 1'b1;
          imm_wide_d = !b[1] && b[0];
          state_d    = S_MODRM_D;
        end else if ((b & x86s_pkg::MASK_F0) == x86s_pkg::OPC_JCC ||
                     (b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_LOOP) begin
          modrm_d = b;  // opcode kept for the condition
          state_d = S_JMP_D;
        end else begin
          st_d    = x86s_pkg::ST_DEC_ERR;
          state_d = S_DONE;
        end
      end
      S_MODRM_D: begin
        modrm_d   = b;
        reg_idx_d = {w_q, mid_f};
        rm_mem_d  = (mod_f != 2'd3);
        rm_reg_d  = {w_q, rm_f};
        disp_d    = '0;
        need_disp = (mod_f == 2'd1) || (mod_f == 2'd2) ||
                    (mod_f == 2'd0 && rm_f == x86s_pkg::RM_DIRECT);
        if (is_grp_q) begin
          unique case (mid_f)
            x86s_pkg::GRP_ADD: kind_d = x86s_pkg::K_ADD;
            x86s_pkg::GRP_SUB: kind_d = x86s_pkg::K_SUB;
            default:           kind_d = x86s_pkg::K_CMP;
          endcase
        end
        priority if ((is_c6_q && (b & x86s_pkg::MODRM_MID_MASK) != 8'h00) ||
                     (is_grp_q && mid_f != x86s_pkg::GRP_ADD &&
                      mid_f != x86s_pkg::GRP_SUB && mid_f != x86s_pkg::GRP_CMP)) begin
          st_d    = x86s_pkg::ST_DEC_ERR;
          state_d = S_DONE;
        end else if (need_disp) begin
          state_d = S_DISP_LO_D;
        end else if (has_imm_q) begin
          state_d = S_IMM_LO_D;
        end else if (mod_f != 2'd3) begin
          state_d = S_EA_B1;
        end else begin
          state_d = S_OPR1;
        end
      end
      S_DISP_LO_D: begin
        disp_wide = (modrm_q[7:6] != 2'd1);
        disp_d    = disp_wide ? {8'h00, b} : x86s_pkg::sext8(b);
        state_d   = disp_wide ? S_DISP_HI_D : after_disp;
      end
      S_DISP_HI_D: begin
        disp_d[15:8] = b;
        state_d      = after_disp;
      end
      S_IMM_LO_D: begin
        imm_d   = imm_wide_q ? {8'h00, b} : x86s_pkg::sext8(b);
        state_d = imm_wide_q ? S_IMM_HI_D : after_imm;
      end
      S_IMM_HI_D: begin
        imm_d[15:8] = b;
        state_d     = after_imm;
      end
      S_EA_B1: begin
        ea_d    = direct ? 16'h0000 : rf_rdata;
        state_d = S_EA_B2;
      end
      S_EA_B2: begin
        ea_d    = alu_y;
        state_d = S_EA_DISP;
      end
      S_EA_DISP: begin
        ea_d    = alu_y;
        state_d = S_RD_LO_D;
      end
      S_RD_LO_D: begin
        mval_d  = {8'h00, b};
        state_d = w_q ? S_RD_HI_D : S_OPR1;
      end
      S_RD_HI_D: begin
        mval_d[15:8] = b;
        state_d      = S_OPR1;
      end
      S_OPR1: begin
        rmv_d   = rm_mem_q ? mval_q : x86s_pkg::reg_fmt(rm_reg_q, rf_rdata);
        state_d = S_EXEC;
      end
      S_EXEC: begin
        res_d = res;
        if (kind_q != x86s_pkg::K_MOV) begin
          zf_d = alu_zf;
          sf_d = alu_sf;
        end
        ip_d    = tip_q;
        st_d    = x86s_pkg::ST_OK;
        state_d = S_DONE;
        if (kind_q != x86s_pkg::K_CMP) begin
          if (!dst_regf && rm_mem_q) begin
            mem_we = 1'b1;
            if (w_q) state_d = S_WR_HI;
          end else begin
            rf_we = 1'b1;
          end
        end
      end
      S_WR_HI: begin
        mem_we    = 1'b1;
        mem_waddr = ea_q + 16'd1;
        mem_wdata = res_q[15:8];
        state_d   = S_DONE;
      end
      S_JMP_D: begin
        if (modrm_q == x86s_pkg::OPC_JE || modrm_q == x86s_pkg::OPC_JNE ||
            modrm_q == x86s_pkg::OPC_JS || modrm_q == x86s_pkg::OPC_JNS) begin
          ip_d = take ? alu_y : tip_q;
          st_d = x86s_pkg::ST_OK;
        end else begin
          ip_d = tip_q;
          st_d = x86s_pkg::ST_NOT_EXEC;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          out_rv_d = rv_q; out_ip_d = ip_q; out_zf_d = zf_q;
          out_sf_d = sf_q; out_st_d = st_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // read ports follow the consuming state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = tip_q;
    tip_d     = tip_q;
    rf_raddr  = 3'd0;
    unique case (state_d)
      S_OP_D, S_MODRM_D, S_DISP_LO_D, S_DISP_HI_D, S_IMM_LO_D, S_IMM_HI_D, S_JMP_D: begin
        mem_re    = 1'b1;
        mem_raddr = (state_q == S_IDLE) ? ip_q : tip_q;
        tip_d     = mem_raddr + 16'd1;
      end
      S_MRD_D: begin
        mem_re    = 1'b1;
        mem_raddr = req_i.address;
      end
      S_RD_LO_D: begin
        mem_re    = 1'b1;
        mem_raddr = ea_d;
      end
      S_RD_HI_D: begin
        mem_re    = 1'b1;
        mem_raddr = ea_q + 16'd1;
      end
      S_REGRD_D: rf_raddr = x86s_pkg::word_idx(req_i.reg_index);
      S_EA_B1:   rf_raddr = x86s_pkg::ea_base1(modrm_d[2:0]);
      S_EA_B2:   rf_raddr = x86s_pkg::ea_base2(modrm_q[2:0]);
      S_OPR1:    rf_raddr = x86s_pkg::word_idx(rm_reg_d);
      S_EXEC:    rf_raddr = x86s_pkg::word_idx(reg_idx_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ip_q        <= '0;
      zf_q        <= 1'b0;
      sf_q        <= 1'b0;
      prog_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ip_q        <= ip_d;
      zf_q        <= zf_d;
      sf_q        <= sf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) prog_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tip_q <= tip_d; kind_q <= kind_d; w_q <= w_d; d_q <= d_d;
    has_imm_q <= has_imm_d; imm_wide_q <= imm_wide_d;
    is_c6_q <= is_c6_d; is_grp_q <= is_grp_d; modrm_q <= modrm_d;
    rm_mem_q <= rm_mem_d; rm_reg_q <= rm_reg_d; reg_idx_q <= reg_idx_d;
    disp_q <= disp_d; imm_q <= imm_d; ea_q <= ea_d; mval_q <= mval_d;
    rmv_q <= rmv_d; res_q <= res_d; rv_q <= rv_d; st_q <= st_d;
    out_rv_q <= out_rv_d; out_ip_q <= out_ip_d; out_zf_q <= out_zf_d;
    out_sf_q <= out_sf_d; out_st_q <= out_st_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.read_value    = out_rv_q;
  assign rsp_o.instr_pointer = out_ip_q;
  assign rsp_o.zero_flag     = out_zf_q;
  assign rsp_o.sign_flag     = out_sf_q;
  assign rsp_o.status        = out_st_q;

  a_ready_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !mem_busy) else $error("request taken during clearing pass");

  a_rf_write_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rf_we |-> (state_q == S_EXEC)) else $error("register write outside execute");

  a_mem_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_EXEC || state_q == S_WR_HI))
    else $error("memory write from unexpected state");

  a_ip_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ip_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_JMP_D))
    else $error("ip changed outside an executing state");

  a_error_keeps_ip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && st_q == x86s_pkg::ST_DEC_ERR) |-> $stable(ip_q))
    else $error("decode error moved ip");
endmodule
`default_nettype wire

// ----- tb/x86s_tb_if.sv -----
`timescale 1ns / 100ps
package x86s_tb_pkg;
  typedef enum logic [1:0] {LOC_REG, LOC_MEM, LOC_IMM} loc_e;
endpackage

// ----- tb/tb_x86_16_subset_decode_execute.sv -----
`timescale 1ns / 100ps
module tb_x86_16_subset_decode_execute;

  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles   = 30;

  typedef struct packed {
    logic [15:0] read_value;
    logic [15:0] instr_pointer;
    logic        zero_flag;
    logic        sign_flag;
    logic [1:0]  status;
  } core_rsp_t;

  typedef struct packed {
    x86s_tb_pkg::loc_e loc;
    logic [3:0]  r;
    logic [15:0] a;
    logic [15:0] imm;
  } opnd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  x86s_req_if req_if ();
  x86s_rsp_if rsp_if ();

  x86_16_subset_decode_execute dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  // shadow state of the core
  logic [7:0]  mem_img [0:65535];
  logic [15:0] regs [0:7];
  logic [15:0] ip_q;
  logic        zf_q;
  logic        sf_q;
  logic [16:0] plen_q;
  logic [15:0] fetch_ptr;

  core_rsp_t   expected_rsp [$];
  logic [7:0]  prog_bytes [$];
  int          errors;
  int          items_sent;
  bit          quiet;
  int          stall_left;
  int          idle_cycles;

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------- predictor ----------------
  function automatic logic [7:0] fetch8();
    logic [7:0] v;
    v = mem_img[fetch_ptr];
    fetch_ptr = fetch_ptr + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] fetch_imm(bit wide);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = fetch8();
    if (wide) begin
      hi = fetch8();
      return {hi, lo};
    end
    return {{8{lo[7]}}, lo};
  endfunction

  function automatic logic [15:0] reg_value(logic [3:0] i);
    if (i[3]) return regs[i[2:0]];
    else if (i[2]) return {8'h00, regs[i[1:0]][15:8]};
    else return {8'h00, regs[i[1:0]][7:0]};
  endfunction

  function automatic void reg_store(logic [3:0] i, logic [15:0] v);
    if (i[3]) regs[i[2:0]] = v;
    else if (i[2]) regs[i[1:0]][15:8] = v[7:0];
    else regs[i[1:0]][7:0] = v[7:0];
  endfunction

  function automatic opnd_t reg_opnd(logic [3:0] r);
    opnd_t o;
    o = '0;
    o.loc = x86s_tb_pkg::LOC_REG;
    o.r = r;
    return o;
  endfunction

  function automatic opnd_t rm_opnd(logic [1:0] md, logic [2:0] rm, logic w);
    opnd_t o;
    logic [15:0] ea;
    o = '0;
    if (md == 2'd3) return reg_opnd({w, rm});
    if (md == 2'd0 && rm == x86s_pkg::RM_DIRECT) begin
      ea = fetch_imm(1'b1);
    end else begin
      case (rm)
        3'd0: ea = regs[3] + regs[6];
        3'd1: ea = regs[3] + regs[7];
        3'd2: ea = regs[5] + regs[6];
        3'd3: ea = regs[5] + regs[7];
        3'd4: ea = regs[6];
        3'd5: ea = regs[7];
        3'd6: ea = regs[5];
        default: ea = regs[3];
      endcase
      if (md == 2'd1) ea = ea + fetch_imm(1'b0);
      else if (md == 2'd2) ea = ea + fetch_imm(1'b1);
    end
    o.loc = x86s_tb_pkg::LOC_MEM;
    o.a = ea;
    return o;
  endfunction

  function automatic logic [15:0] opnd_read(opnd_t o, logic w);
    logic [15:0] a1;
    logic [15:0] v;
    a1 = o.a + 16'd1;
    case (o.loc)
      x86s_tb_pkg::LOC_REG: v = reg_value(o.r);
      x86s_tb_pkg::LOC_IMM: v = o.imm;
      default: v = {mem_img[a1], mem_img[o.a]};
    endcase
    return w ? v : {8'h00, v[7:0]};
  endfunction

  function automatic void opnd_write(opnd_t o, logic w, logic [15:0] v);
    logic [15:0] a1;
    a1 = o.a + 16'd1;
    if (o.loc == x86s_tb_pkg::LOC_REG) reg_store(o.r, v);
    else if (o.loc == x86s_tb_pkg::LOC_MEM) begin
      mem_img[o.a] = v[7:0];
      if (w) mem_img[a1] = v[15:8];
    end
  endfunction

  function automatic logic [1:0] exec_instr();
    logic [7:0]  b;
    logic [7:0]  b2;
    logic [7:0]  hi;
    logic        w;
    logic        take;
    x86s_pkg::kind_e k;
    opnd_t       dst;
    opnd_t       src;
    opnd_t       t;
    logic [15:0] av;
    logic [15:0] cv;
    logic [15:0] rv;
    logic [15:0] disp;
    if ({1'b0, ip_q} >= plen_q) return x86s_pkg::ST_FINISHED;
    fetch_ptr = ip_q;
    b = fetch8();
    hi = b & x86s_pkg::MASK_FC;
    if (hi == x86s_pkg::OPC_ADD_RM || hi == x86s_pkg::OPC_SUB_RM ||
        hi == x86s_pkg::OPC_CMP_RM || hi == x86s_pkg::OPC_MOV_RM) begin
      k = (hi == x86s_pkg::OPC_MOV_RM) ? x86s_pkg::K_MOV :
          (hi == x86s_pkg::OPC_ADD_RM) ? x86s_pkg::K_ADD :
          (hi == x86s_pkg::OPC_SUB_RM) ? x86s_pkg::K_SUB : x86s_pkg::K_CMP;
      b2 = fetch8();
      w = b[0];
      src = reg_opnd({w, b2[5:3]});
      dst = rm_opnd(b2[7:6], b2[2:0], w);
      if (b[1]) begin
        t = dst;
        dst = src;
        src = t;
      end
    end else if ((b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_ADD_ACC ||
                 (b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_SUB_ACC ||
                 (b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_CMP_ACC) begin
      hi = b & x86s_pkg::MASK_FE;
      k = (hi == x86s_pkg::OPC_ADD_ACC) ? x86s_pkg::K_ADD :
          (hi == x86s_pkg::OPC_SUB_ACC) ? x86s_pkg::K_SUB : x86s_pkg::K_CMP;
      w = b[0];
      src = '0;
      src.loc = x86s_tb_pkg::LOC_IMM;
      src.imm = fetch_imm(w);
      dst = reg_opnd({w, 3'd0});
    end else if ((b & x86s_pkg::MASK_F0) == x86s_pkg::OPC_MOV_RI) begin
      k = x86s_pkg::K_MOV;
      w = b[3];
      src = '0;
      src.loc = x86s_tb_pkg::LOC_IMM;
      src.imm = fetch_imm(w);
      dst = reg_opnd({w, b[2:0]});
    end else if ((b & x86s_pkg::MASK_FE) == x86s_pkg::OPC_MOV_MI) begin
      k = x86s_pkg::K_MOV;
      w = b[0];
      b2 = fetch8();
      if ((b2 & x86s_pkg::MODRM_MID_MASK) != 8'h00) return x86s_pkg::ST_DEC_ERR;
      dst = rm_opnd(b2[7:6], b2[2:0], w);
      src = '0;
      src.loc = x86s_tb_pkg::LOC_IMM;
      src.imm = fetch_imm(w);
    end else if ((b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_GRP) begin
      w = b[0];
      b2 = fetch8();
      if (b2[5:3] == x86s_pkg::GRP_ADD) k = x86s_pkg::K_ADD;
      else if (b2[5:3] == x86s_pkg::GRP_SUB) k = x86s_pkg::K_SUB;
      else if (b2[5:3] == x86s_pkg::GRP_CMP) k = x86s_pkg::K_CMP;
      else return x86s_pkg::ST_DEC_ERR;
      dst = rm_opnd(b2[7:6], b2[2:0], w);
      src = '0;
      src.loc = x86s_tb_pkg::LOC_IMM;
      src.imm = fetch_imm(!b[1] && w);
    end else if ((b & x86s_pkg::MASK_F0) == x86s_pkg::OPC_JCC ||
                 (b & x86s_pkg::MASK_FC) == x86s_pkg::OPC_LOOP) begin
      disp = fetch_imm(1'b0);
      if (b == x86s_pkg::OPC_JE) take = zf_q;
      else if (b == x86s_pkg::OPC_JNE) take = !zf_q;
      else if (b == x86s_pkg::OPC_JS) take = sf_q;
      else if (b == x86s_pkg::OPC_JNS) take = !sf_q;
      else begin
        ip_q = fetch_ptr;
        return x86s_pkg::ST_NOT_EXEC;
      end
      ip_q = take ? fetch_ptr + disp : fetch_ptr;
      return x86s_pkg::ST_OK;
    end else begin
      return x86s_pkg::ST_DEC_ERR;
    end
    av = opnd_read(dst, w);
    cv = opnd_read(src, w);
    if (k == x86s_pkg::K_MOV) begin
      opnd_write(dst, w, cv);
    end else begin
      rv = (k == x86s_pkg::K_ADD) ? av + cv : av - cv;
      if (!w) rv[15:8] = 8'h00;
      if (k != x86s_pkg::K_CMP) opnd_write(dst, w, rv);
      zf_q = (rv == 16'h0000);
      sf_q = w ? rv[15] : rv[7];
    end
    ip_q = fetch_ptr;
    return x86s_pkg::ST_OK;
  endfunction

  function automatic core_rsp_t predict_rsp(logic [1:0] rt, logic [15:0] addr,
                                             logic [7:0] data, logic [3:0] idx);
    core_rsp_t e;
    e = '0;
    case (rt)
      x86s_pkg::REQ_MEM_WR: mem_img[addr] = data;
      x86s_pkg::REQ_STEP:   e.status = exec_instr();
      x86s_pkg::REQ_REG_RD: e.read_value = reg_value(idx);
      default:              e.read_value = {8'h00, mem_img[addr]};
    endcase
    e.instr_pointer = ip_q;
    e.zero_flag = zf_q;
    e.sign_flag = sf_q;
    return e;
  endfunction

  // ---------------- drivers ----------------
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue_req(logic [1:0] rt, logic [15:0] addr, logic [7:0] data,
                           logic [3:0] idx);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.req_type   <= rt;
    req_if.address    <= addr;
    req_if.write_byte <= data;
    req_if.reg_index  <= idx;
    do @(posedge clk_i); while (!req_if.ready);
    expected_rsp.push_back(predict_rsp(rt, addr, data, idx));
    items_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    req_if.valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_length(logic [16:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    plen_q = v;
  endtask

  task automatic load_prog(logic [15:0] base);
    foreach (prog_bytes[i])
      issue_req(x86s_pkg::REQ_MEM_WR, base + 16'(i), prog_bytes[i], 4'($urandom));
  endtask

  task automatic step_req();
    issue_req(x86s_pkg::REQ_STEP, 16'($urandom), 8'($urandom), 4'($urandom));
  endtask

  // ---------------- program generator ----------------
  function automatic void push_disp(logic [1:0] md, logic [2:0] rm);
    if (md == 2'd1) prog_bytes.push_back(8'($urandom));
    else if (md == 2'd2 || (md == 2'd0 && rm == x86s_pkg::RM_DIRECT)) begin
      prog_bytes.push_back(8'($urandom));
      prog_bytes.push_back(8'($urandom));
    end
  endfunction

  function automatic void push_imm(bit wide);
    prog_bytes.push_back(8'($urandom));
    if (wide) prog_bytes.push_back(8'($urandom));
  endfunction

  function automatic void gen_instr();
    logic [7:0] op;
    logic [7:0] mrm;
    logic [2:0] mid;
    int         sel;
    sel = $urandom_range(0, 2);
    mrm = 8'($urandom);
    case ($urandom_range(0, 15))
      0, 1: begin
        op = x86s_pkg::OPC_MOV_RM | 8'($urandom_range(0, 3));
        prog_bytes.push_back(op);
        prog_bytes.push_back(mrm);
        push_disp(mrm[7:6], mrm[2:0]);
      end
      2, 3, 4: begin
        op = (sel == 0 ? x86s_pkg::OPC_ADD_RM : sel == 1 ? x86s_pkg::OPC_SUB_RM :
              x86s_pkg::OPC_CMP_RM) | 8'($urandom_range(0, 3));
        prog_bytes.push_back(op);
        prog_bytes.push_back(mrm);
        push_disp(mrm[7:6], mrm[2:0]);
      end
      5: begin
        op = (sel == 0 ? x86s_pkg::OPC_ADD_ACC : sel == 1 ? x86s_pkg::OPC_SUB_ACC :
              x86s_pkg::OPC_CMP_ACC) | 8'($urandom_range(0, 1));
        prog_bytes.push_back(op);
        push_imm(op[0]);
      end
      8: begin
        op = x86s_pkg::OPC_MOV_MI | 8'($urandom_range(0, 1));
        if ($urandom_range(0, 7) != 0) mrm[5:3] = 3'd0;
        prog_bytes.push_back(op);
        prog_bytes.push_back(mrm);
        push_disp(mrm[7:6], mrm[2:0]);
        push_imm(op[0]);
      end
      9, 10: begin
        op = x86s_pkg::OPC_GRP | 8'($urandom_range(0, 3));
        mid = sel == 0 ? x86s_pkg::GRP_ADD : sel == 1 ? x86s_pkg::GRP_SUB :
              x86s_pkg::GRP_CMP;
        if ($urandom_range(0, 7) != 0) mrm[5:3] = mid;
        prog_bytes.push_back(op);
        prog_bytes.push_back(mrm);
        push_disp(mrm[7:6], mrm[2:0]);
        push_imm(!op[1] && op[0]);
      end
      11, 12: begin
        case ($urandom_range(0, 5))
          0: op = x86s_pkg::OPC_JE;
          1: op = x86s_pkg::OPC_JNE;
          2: op = x86s_pkg::OPC_JS;
          3: op = x86s_pkg::OPC_JNS;
          4: op = x86s_pkg::OPC_JCC | 8'($urandom_range(0, 15));
          default: op = x86s_pkg::OPC_LOOP | 8'($urandom_range(0, 3));
        endcase
        prog_bytes.push_back(op);
        prog_bytes.push_back($urandom_range(0, 3) != 0 ? 8'($urandom_range(0, 6)) :
                             8'($urandom));
      end
      13: begin
        repeat (4) prog_bytes.push_back(8'($urandom));
      end
      default: begin
        op = x86s_pkg::OPC_MOV_RI | 8'($urandom_range(0, 15));
        prog_bytes.push_back(op);
        push_imm(op[3]);
      end
    endcase
  endfunction

  // ---------------- response side ----------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 59) == 0) begin
      stall_left = $urandom_range(8, 40);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    core_rsp_t e;
    if (rsp_if.valid && rsp_if.ready) begin
      if (expected_rsp.size() == 0) begin
        $error("result with no transfer outstanding");
        errors++;
      end else begin
        e = expected_rsp.pop_front();
        if (rsp_if.read_value !== e.read_value) begin
          $error("read_value exp %h got %h", e.read_value, rsp_if.read_value);
          errors++;
        end
        if (rsp_if.instr_pointer !== e.instr_pointer) begin
          $error("instr_pointer exp %h got %h", e.instr_pointer, rsp_if.instr_pointer);
          errors++;
        end
        if (rsp_if.zero_flag !== e.zero_flag) begin
          $error("zero_flag exp %b got %b", e.zero_flag, rsp_if.zero_flag);
          errors++;
        end
        if (rsp_if.sign_flag !== e.sign_flag) begin
          $error("sign_flag exp %b got %b", e.sign_flag, rsp_if.sign_flag);
          errors++;
        end
        if (rsp_if.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, rsp_if.status);
          errors++;
        end
      end
    end
  end

  // covers the memory clear after reset as well
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_reset_state();
    for (int i = 0; i < 16; i++) issue_req(x86s_pkg::REQ_REG_RD, 16'hFFFF, 8'hFF, 4'(i));
    issue_req(x86s_pkg::REQ_MEM_RD, 16'h0000, 8'h00, 4'hF);
    issue_req(x86s_pkg::REQ_MEM_RD, 16'hFFFF, 8'hFF, 4'h0);
    step_req();  // length zero: finished
  endtask

  task automatic test_directed_program();
    logic [7:0] prog [] = '{
      8'hB8, 8'h34, 8'h12,              // mov ax,1234
      8'hB3, 8'h80, 8'hB7, 8'hFF,       // mov bl,80 / mov bh,ff
      8'h88, 8'hC1,                     // mov cl,al
      8'h89, 8'h1E, 8'h00, 8'h20,       // mov [2000],bx
      8'h8B, 8'h16, 8'h00, 8'h20,       // mov dx,[2000]
      8'hC7, 8'h06, 8'h02, 8'h20, 8'hFF, 8'h7F,
      8'hC6, 8'h47, 8'h05, 8'hAA,       // mov byte [bx+5],aa
      8'h01, 8'hC0,                     // add ax,ax
      8'h2D, 8'h68, 8'h24,              // sub ax,2468 -> zero
      8'h74, 8'h02, 8'h0F, 8'h0F,       // je over junk
      8'h3C, 8'h80,                     // cmp al,80 -> sign
      8'h78, 8'h00,                     // js +0
      8'h83, 8'hE8, 8'h01,              // sub ax,sext 1
      8'h81, 8'h3E, 8'h00, 8'h20, 8'h80, 8'hFF,
      8'h05, 8'hFF, 8'h7F,              // add ax,7fff
      8'h75, 8'hFE, 8'h79, 8'h00,       // jne back to itself is taken (zf clear), ip stays
      8'h70, 8'h05, 8'hE2, 8'hFE,       // not executed
      8'h8C, 8'hC0                      // segment mov: error
    };
    prog_bytes.delete();
    foreach (prog[i]) prog_bytes.push_back(prog[i]);
    load_prog(16'h0000);
    set_length(17'h10000);
    repeat (22) step_req();
    issue_req(x86s_pkg::REQ_MEM_RD, 16'h2005, 8'h00, 4'h0);
    issue_req(x86s_pkg::REQ_MEM_RD, 16'h1F85, 8'h00, 4'h0);
    issue_req(x86s_pkg::REQ_REG_RD, 16'h0000, 8'h00, 4'hA);
    // other decode errors at the stuck ip
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q, 8'hA1, 4'h0);
    step_req();
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q, x86s_pkg::OPC_MOV_MI, 4'h0);
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q + 16'd1, 8'h08, 4'h0);
    step_req();
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q, x86s_pkg::OPC_GRP, 4'h0);
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q + 16'd1, 8'hC9, 4'h0);
    step_req();
    issue_req(x86s_pkg::REQ_MEM_WR, ip_q, 8'h0F, 4'h0);
    step_req();
    set_length({1'b0, ip_q});
    step_req();  // at length: finished
    set_length(17'h0FFFF);
  endtask

  task automatic test_random_programs();
    int n;
    int extra;
    logic [16:0] len;
    while (items_sent < 850) begin
      quiet = ($urandom_range(0, 4) == 0);
      prog_bytes.delete();
      n = $urandom_range(4, 14);
      repeat (n) gen_instr();
      load_prog(ip_q);
      len = {1'b0, ip_q} + 17'(prog_bytes.size());
      case ($urandom_range(0, 7))
        0: len = 17'h10000;
        1: len = 17'h0FFFF;
        2: len = 17'h00000;
        3: len = 17'($urandom);
        default: if (len > 17'h10000) len = 17'h10000;
      endcase
      // every block waits out outstanding results before reconfiguring
      set_length(len);
      extra = $urandom_range(0, 3);
      repeat (n + extra) begin
        if ($urandom_range(0, 5) == 0)
          issue_req(x86s_pkg::REQ_REG_RD, 16'($urandom), 8'($urandom), 4'($urandom));
        if ($urandom_range(0, 9) == 0)
          issue_req(x86s_pkg::REQ_MEM_RD, 16'($urandom), 8'($urandom), 4'($urandom));
        if ($urandom_range(0, 19) == 0)
          issue_req(x86s_pkg::REQ_MEM_WR, 16'($urandom), 8'($urandom), 4'($urandom));
        step_req();
      end
      for (int i = 8; i < 16; i++)
        issue_req(x86s_pkg::REQ_REG_RD, 16'($urandom), 8'($urandom), 4'(i));
    end
    quiet = 1'b0;
  endtask

  initial begin
    foreach (mem_img[i]) mem_img[i] = 8'h00;
    foreach (regs[i]) regs[i] = 16'h0000;
    ip_q = '0;
    zf_q = 1'b0;
    sf_q = 1'b0;
    plen_q = '0;
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    idle_cycles = 0;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.req_type <= x86s_pkg::REQ_MEM_WR;
    req_if.address <= '0;
    req_if.write_byte <= '0;
    req_if.reg_index <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_directed_program();
    test_random_programs();
    wait_drained();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
